FILE: sv/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Fixed-point format, internal widths and the job and result records.
// ----------------------------------------------------------------------------
package mi3_pkg;

  // Q16.16 entries
  localparam int unsigned FracBits = 16;
  localparam int unsigned InW      = 32;
  // cofactor magnitude (p*q - r*s stays within 2^63)
  localparam int unsigned CofW     = 64;
  // determinant magnitude (three terms below 2^94 each)
  localparam int unsigned DetW     = 96;
  // divider: quotient of 2*cof*2^(2F)/det, one overflow bit on top
  localparam int unsigned QuoW     = InW + 2;
  localparam int unsigned RemW     = CofW + 2 * FracBits + 1;
  localparam int unsigned DvsW     = DetW + QuoW - 1;
  localparam int unsigned ThrW     = 31;

  // classified matrix handed from the front end to the divider
  typedef struct packed {
    logic [8:0]           cof_neg;
    logic [8:0][CofW-1:0] cof_mag;
    logic                 det_neg;
    logic [DetW-1:0]      det_mag;
    logic                 singular;
  } mi3_job_t;

  // one finished inverse
  typedef struct packed {
    logic [8:0][InW-1:0] inv;
    logic                singular;
    logic                saturated;
  } mi3_res_t;

endpackage

FILE: sv/mi3_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_front: cofactor and determinant pipeline
// Five stages: products, cofactors, determinant partial products, determinant
// sum, magnitude and singular test. The whole pipe holds when its last stage
// cannot hand its job on.
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [8:0][mi3_pkg::InW-1:0]      a_i,
  input  logic [mi3_pkg::ThrW-1:0]          thr_i,
  output logic                              job_valid_o,
  input  logic                              job_ready_i,
  output mi3_pkg::mi3_job_t                 job_o
);
  import mi3_pkg::*;

  // cofactor k = a[IdxA]*a[IdxB] - a[IdxC]*a[IdxD]
  localparam int IdxA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int IdxB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int IdxC [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int IdxD [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
  // first-row expansion uses cofactors 0, 3 and 6
  localparam int CofSel [3] = '{0, 3, 6};
  localparam int unsigned ThrSh = 2 * FracBits;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  logic signed [2*InW-1:0] pa_q [9];
  logic signed [2*InW-1:0] pb_q [9];
  logic [2:0][InW-1:0]     top1_q, top2_q;

  logic [8:0][2*InW:0]     diff, ndiff;
  logic [2:0][InW-1:0]     am;

  logic [8:0]              cneg2_q, cneg3_q, cneg4_q;
  logic [8:0][CofW-1:0]    cmag2_q, cmag3_q, cmag4_q;

  logic [2*InW-1:0]        plo3_q [3];
  logic [2*InW-1:0]        phi3_q [3];
  logic [2:0]              tneg3_q;

  logic signed [DetW:0]    det4_q;
  mi3_job_t                job5_q;

  // hold every stage while the last one waits
  assign en          = !(v5_q && !job_ready_i);
  assign in_ready_o  = en;
  assign job_valid_o = v5_q;
  assign job_o       = job5_q;

  // advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // stage 1: the eighteen entry products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pa_q[k] <= $signed(a_i[IdxA[k]]) * $signed(a_i[IdxB[k]]);
        pb_q[k] <= $signed(a_i[IdxC[k]]) * $signed(a_i[IdxD[k]]);
      end
      top1_q <= {a_i[2], a_i[1], a_i[0]};
    end
  end

  // stage 2: cofactors as sign and magnitude
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      diff[k]  = {pa_q[k][2*InW-1], pa_q[k]} - {pb_q[k][2*InW-1], pb_q[k]};
      ndiff[k] = -diff[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        cneg2_q[k] <= diff[k][2*InW];
        cmag2_q[k] <= diff[k][2*InW] ? ndiff[k][CofW-1:0] : diff[k][CofW-1:0];
      end
      top2_q <= top1_q;
    end
  end

  // stage 3: first-row entry times cofactor, split into two 32x32 products
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      am[j] = top2_q[j][InW-1] ? (~top2_q[j] + 1'b1) : top2_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo3_q[j]  <= am[j] * cmag2_q[CofSel[j]][InW-1:0];
        phi3_q[j]  <= am[j] * cmag2_q[CofSel[j]][CofW-1:InW];
        tneg3_q[j] <= top2_q[j][InW-1] ^ cneg2_q[CofSel[j]];
      end
      cneg3_q <= cneg2_q;
      cmag3_q <= cmag2_q;
    end
  end

  // stage 4: assemble signed terms and add them
  logic signed [DetW:0] sterm [3];
  always_comb begin
    logic [DetW-1:0] tmag;
    for (int j = 0; j < 3; j++) begin
      tmag     = {phi3_q[j], {InW{1'b0}}} + {{InW{1'b0}}, plo3_q[j]};
      sterm[j] = tneg3_q[j] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det4_q  <= sterm[0] + sterm[1] + sterm[2];
      cneg4_q <= cneg3_q;
      cmag4_q <= cmag3_q;
    end
  end

  // stage 5: determinant magnitude and singular test
  logic [DetW:0]   ndet;
  logic [DetW-1:0] dmag;
  assign ndet = -det4_q;
  assign dmag = det4_q[DetW] ? ndet[DetW-1:0] : det4_q[DetW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      job5_q.cof_neg  <= cneg4_q;
      job5_q.cof_mag  <= cmag4_q;
      job5_q.det_neg  <= det4_q[DetW];
      job5_q.det_mag  <= dmag;
      job5_q.singular <= dmag <= (DetW'(thr_i) << ThrSh);
    end
  end

endmodule

FILE: sv/mi3_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_queue: job queue between front end and divider
// Circular buffer with read and write pointers and a fill count.
// ----------------------------------------------------------------------------
module mi3_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mi3_pkg::mi3_job_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output mi3_pkg::mi3_job_t rdata_o,
  output logic              empty_o
);
  import mi3_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  mi3_job_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_q];

  // store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  // move pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/mi3_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_back: reciprocal scaling and result register
// Nine restoring-division lanes share one shifted divisor and produce one
// quotient bit each per cycle; the done state then rounds, saturates and signs.
// ----------------------------------------------------------------------------
module mi3_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  mi3_pkg::mi3_job_t job_i,
  output logic              job_pop_o,
  output logic              res_valid_o,
  input  logic              res_pop_i,
  output mi3_pkg::mi3_res_t res_o
);
  import mi3_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;
  localparam int unsigned CntW  = $clog2(QuoW);
  localparam int unsigned NumSh = 2 * FracBits + 1;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  cnt_q;
  logic [DvsW-1:0]  dvs_q;
  logic [RemW-1:0]  rem_q [9];
  logic [QuoW-1:0]  quo_q [9];
  logic [8:0]       neg_q;
  logic             sing_q;
  logic             out_v_q;
  mi3_res_t         res_q;

  logic             load_out;
  logic [8:0]       ge;
  logic [RemW-1:0]  sub [9];
  logic [8:0][InW-1:0] inv;
  logic [8:0]       sat;

  assign job_pop_o   = (state_q == StIdle) && job_valid_i;
  assign load_out    = (state_q == StDone) && (!out_v_q || res_pop_i);
  assign res_valid_o = out_v_q;
  assign res_o       = res_q;

  // compare and subtract in every lane
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ge[k]  = {{(DvsW - RemW){1'b0}}, rem_q[k]} >= dvs_q;
      sub[k] = rem_q[k] - dvs_q[RemW-1:0];
    end
  end

  // round half away from zero, clip, apply sign
  always_comb begin
    logic [QuoW-1:0] rnd, lim, m;
    for (int k = 0; k < 9; k++) begin
      rnd    = ({1'b0, quo_q[k][QuoW-2:0]} + 1'b1) >> 1;
      lim    = neg_q[k] ? QuoW'(34'h0_8000_0000) : QuoW'(34'h0_7FFF_FFFF);
      sat[k] = quo_q[k][QuoW-1] || (rnd > lim);
      m      = sat[k] ? lim : rnd;
      inv[k] = neg_q[k] ? (~m[InW-1:0] + 1'b1) : m[InW-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (job_valid_i) state_d = StRun;
      StRun:  if (cnt_q == '0) state_d = StDone;
      StDone: if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (res_pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // load a job, then shift out one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cnt_q  <= CntW'(QuoW - 1);
      dvs_q  <= DvsW'(job_i.det_mag) << (QuoW - 1);
      neg_q  <= job_i.cof_neg ^ {9{job_i.det_neg}};
      sing_q <= job_i.singular;
      for (int k = 0; k < 9; k++) begin
        rem_q[k] <= RemW'(job_i.cof_mag[k]) << NumSh;
        quo_q[k] <= '0;
      end
    end else if (state_q == StRun) begin
      cnt_q <= cnt_q - 1'b1;
      dvs_q <= dvs_q >> 1;
      for (int k = 0; k < 9; k++) begin
        rem_q[k] <= ge[k] ? sub[k] : rem_q[k];
        quo_q[k] <= {quo_q[k][QuoW-2:0], ge[k]};
      end
    end
  end

  // result register; a singular matrix gives zeros
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_q.inv       <= sing_q ? '0 : inv;
      res_q.singular  <= sing_q;
      res_q.saturated <= !sing_q && (|sat);
    end
  end

endmodule

FILE: sv/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3: fixed-point 3x3 inverse by adjugate
// Channel   Direction  Handshake             Content
// input     in         push / full           a00..a22, signed Q16.16
// result    out        empty / pop           inv00..inv22, singular, saturated
// config    in         APB psel/penable      zero_det_threshold at address 0
//
// The front pipeline takes a matrix every cycle while full is low and passes
// it through its registered stages into a job queue. The divider takes one job
// at a time: it fetches it, divides bit-serially, rounds, and only then
// fetches the next; the bit-serial divider lanes set the sustained result rate.
// Reset clears all control state; the threshold resets to zero.
// full rises when the queue is full and the last front stage holds a job.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] a00_i,
  input  logic [31:0] a01_i,
  input  logic [31:0] a02_i,
  input  logic [31:0] a10_i,
  input  logic [31:0] a11_i,
  input  logic [31:0] a12_i,
  input  logic [31:0] a20_i,
  input  logic [31:0] a21_i,
  input  logic [31:0] a22_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] inv00_o,
  output logic [31:0] inv01_o,
  output logic [31:0] inv02_o,
  output logic [31:0] inv10_o,
  output logic [31:0] inv11_o,
  output logic [31:0] inv12_o,
  output logic [31:0] inv20_o,
  output logic [31:0] inv21_o,
  output logic [31:0] inv22_o,
  output logic        singular_o,
  output logic        saturated_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mi3_pkg::*;

  localparam logic RegThreshold = 1'b0;

  logic [ThrW-1:0]     thr_q;
  logic [8:0][InW-1:0] a;
  logic                in_ready;
  logic                f_valid, q_full, q_push;
  logic                q_empty, q_pop;
  mi3_job_t            f_job, q_head;
  logic                res_valid;
  mi3_res_t            res;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegThreshold) ? {1'b0, thr_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegThreshold) begin
      thr_q <= pwdata[ThrW-1:0];
    end
  end

  assign a = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};
  assign full = !in_ready;

  mi3_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (in_ready),
    .a_i         (a),
    .thr_i       (thr_q),
    .job_valid_o (f_valid),
    .job_ready_i (!q_full),
    .job_o       (f_job)
  );

  assign q_push = f_valid && !q_full;

  mi3_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (f_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  mi3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!q_empty),
    .job_i       (q_head),
    .job_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_pop_i   (pop && !empty),
    .res_o       (res)
  );

  // drive result ports
  assign empty       = !res_valid;
  assign inv00_o     = res.inv[0];
  assign inv01_o     = res.inv[1];
  assign inv02_o     = res.inv[2];
  assign inv10_o     = res.inv[3];
  assign inv11_o     = res.inv[4];
  assign inv12_o     = res.inv[5];
  assign inv20_o     = res.inv[6];
  assign inv21_o     = res.inv[7];
  assign inv22_o     = res.inv[8];
  assign singular_o  = res.singular;
  assign saturated_o = res.saturated;

  // checks
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job taken from an empty queue");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && singular_o) |-> (inv00_o == '0 && inv11_o == '0 && inv22_o == '0
                                && !saturated_o))
    else $error("singular result carries non-zero entries");

endmodule
